>>> sv/cfc_pkg.sv
`default_nettype none
package cfc_pkg;

  // Coordinate fraction bits (hit units are 1/2^F cm)
  localparam int COORD_FRAC_BITS_DEF = 4;

  // Q16 constants of the tilted sector frame
  localparam int Q_SIN_TILT    = 27697;
  localparam int Q_INV_SINRHO  = 73626;
  localparam int Q_INV_TGRHO   = 33552;
  localparam int Q_INV_2COSRHO = 71905;
  localparam int Q_YLOW        = -11991384;
  localparam int Q_YHIGH       = 12448956;

  // Bound register reset values
  localparam logic signed [15:0] U_MIN_RST = 16'sd1120;
  localparam logic signed [15:0] U_MAX_RST = 16'sd6480;
  localparam logic signed [15:0] V_MAX_RST = 16'sd5792;
  localparam logic signed [15:0] W_MAX_RST = 16'sd6320;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Rotation coefficient and product widths
  localparam int COEF_W = 18;
  localparam int PRW    = 33;

  typedef enum logic [1:0] {
    REG_U_MIN = 2'd0,
    REG_U_MAX = 2'd1,
    REG_V_MAX = 2'd2,
    REG_W_MAX = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] u_min;
    logic signed [15:0] u_max;
    logic signed [15:0] v_max;
    logic signed [15:0] w_max;
  } bounds_t;

  typedef struct packed {
    logic signed [15:0]    x;
    logic signed [15:0]    y;
    logic signed [PRW-1:0] pz;
    logic [2:0]            sec;
    logic [5:0]            tag;
  } sec_item_t;

  typedef struct packed {
    logic signed [PRW-1:0] yi;
    logic signed [PRW-1:0] xi;
    logic [2:0]            sec;
    logic [5:0]            tag;
  } rot_item_t;

  typedef struct packed {
    logic               in_cut;
    logic [2:0]         sec;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic signed [15:0] w;
    logic [5:0]         tag;
  } res_item_t;

  // cos(tilt)*cos(60k)
  function automatic logic signed [COEF_W-1:0] coef_ctcp(input logic [2:0] k);
    case (k)
      3'd0: return 18'sd59396;
      3'd1: return 18'sd29698;
      3'd2: return -18'sd29698;
      3'd3: return -18'sd59396;
      3'd4: return -18'sd29698;
      3'd5: return 18'sd29698;
      default: return '0;
    endcase
  endfunction

  // cos(tilt)*sin(60k)
  function automatic logic signed [COEF_W-1:0] coef_ctsp(input logic [2:0] k);
    case (k)
      3'd1, 3'd2: return 18'sd51438;
      3'd4, 3'd5: return -18'sd51438;
      default: return '0;
    endcase
  endfunction

  // sin(60k)
  function automatic logic signed [COEF_W-1:0] coef_sp(input logic [2:0] k);
    case (k)
      3'd1, 3'd2: return 18'sd56756;
      3'd4, 3'd5: return -18'sd56756;
      default: return '0;
    endcase
  endfunction

  // cos(60k)
  function automatic logic signed [COEF_W-1:0] coef_cp(input logic [2:0] k);
    case (k)
      3'd0: return 18'sd65536;
      3'd1: return 18'sd32768;
      3'd2: return -18'sd32768;
      3'd3: return -18'sd65536;
      3'd4: return -18'sd32768;
      3'd5: return 18'sd32768;
      default: return '0;
    endcase
  endfunction

endpackage
`default_nettype wire

>>> sv/cfc_regs.sv
`default_nettype none
module cfc_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [cfc_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [cfc_pkg::PDATA_W-1:0]      pwdata,
  output logic      [cfc_pkg::PDATA_W-1:0]      prdata,
  output cfc_pkg::bounds_t                      bounds
);

  cfc_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = cfc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.u_min <= cfc_pkg::U_MIN_RST;
      bounds.u_max <= cfc_pkg::U_MAX_RST;
      bounds.v_max <= cfc_pkg::V_MAX_RST;
      bounds.w_max <= cfc_pkg::W_MAX_RST;
    end else if (wr_en) begin
      case (idx)
        cfc_pkg::REG_U_MIN: bounds.u_min <= pwdata[15:0];
        cfc_pkg::REG_U_MAX: bounds.u_max <= pwdata[15:0];
        cfc_pkg::REG_V_MAX: bounds.v_max <= pwdata[15:0];
        cfc_pkg::REG_W_MAX: bounds.w_max <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cfc_pkg::REG_U_MIN: prdata = {16'b0, bounds.u_min};
      cfc_pkg::REG_U_MAX: prdata = {16'b0, bounds.u_max};
      cfc_pkg::REG_V_MAX: prdata = {16'b0, bounds.v_max};
      cfc_pkg::REG_W_MAX: prdata = {16'b0, bounds.w_max};
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/cfc_sector.sv
`default_nettype none
module cfc_sector (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [15:0] hit_x,
  input  wire logic signed [15:0] hit_y,
  input  wire logic signed [15:0] hit_z,
  input  wire logic [5:0]         track_tag,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfc_pkg::sec_item_t      out_item
);

  localparam int N = 2;
  localparam int PRW = cfc_pkg::PRW;
  localparam logic signed [PRW-1:0] SIN_TILT = PRW'(cfc_pkg::Q_SIN_TILT);

  logic [N-1:0] vld;
  logic [N-1:0] load;

  // stage 1: squares
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  logic signed [15:0] s1_z;
  logic [5:0]         s1_tag;
  logic [31:0]        s1_xsq;
  logic [31:0]        s1_ysq;

  logic signed [33:0] d;
  logic               xneg, xzero, xpos, yneg, yzero, ypos, origin;
  logic               dneg, dzero, dpos;
  logic               a, b, c;
  logic [2:0]         sec_next;

  always_comb begin
    load[N-1] = !vld[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s1_x   <= hit_x;
      s1_y   <= hit_y;
      s1_z   <= hit_z;
      s1_tag <= track_tag;
      s1_xsq <= 32'(hit_x) * 32'(hit_x);
      s1_ysq <= 32'(hit_y) * 32'(hit_y);
    end
  end

  // sign of 3y^2 - x^2 settles the 30/150/210/330 deg rays
  always_comb begin
    d      = $signed(({2'b00, s1_ysq} + {1'b0, s1_ysq, 1'b0}) - {2'b00, s1_xsq});
    dneg   = d[33];
    dzero  = (d == '0);
    dpos   = !dneg && !dzero;
    xneg   = s1_x[15];
    xzero  = (s1_x == '0);
    xpos   = !xneg && !xzero;
    yneg   = s1_y[15];
    yzero  = (s1_y == '0);
    ypos   = !yneg && !yzero;
    origin = xzero && yzero;

    if (!yneg && !xpos) begin
      a = !origin;
    end else if (!ypos && !xneg) begin
      a = 1'b0;
    end else begin
      a = (yneg ? dneg : dpos) || (dzero && ypos);
    end

    if (!ypos && !xpos) begin
      c = !origin;
    end else if (!yneg && !xneg) begin
      c = 1'b0;
    end else begin
      c = (ypos ? dneg : dpos) || (dzero && ypos);
    end

    b = xneg || (xzero && ypos);

    if (a) begin
      sec_next = 3'd1 + {2'b00, b} + {2'b00, c};
    end else if (c) begin
      sec_next = b ? 3'd4 : 3'd5;
    end else begin
      sec_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      out_item.x   <= s1_x;
      out_item.y   <= s1_y;
      out_item.pz  <= PRW'(s1_z) * SIN_TILT;
      out_item.sec <= sec_next;
      out_item.tag <= s1_tag;
    end
  end

endmodule
`default_nettype wire

>>> sv/cfc_rotate.sv
`default_nettype none
module cfc_rotate (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  cfc_pkg::sec_item_t      in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfc_pkg::rot_item_t      out_item
);

  localparam int N = 2;
  localparam int PRW = cfc_pkg::PRW;

  logic [N-1:0] vld;
  logic [N-1:0] load;

  logic signed [PRW-1:0] pxa, pyb, pxs, pyc, pz;
  logic [2:0]            sec;
  logic [5:0]            tag;

  always_comb begin
    load[N-1] = !vld[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 3: one product per table coefficient
  always_ff @(posedge clk) begin
    if (load[0]) begin
      pxa <= PRW'(in_item.x) * PRW'(cfc_pkg::coef_ctcp(in_item.sec));
      pyb <= PRW'(in_item.y) * PRW'(cfc_pkg::coef_ctsp(in_item.sec));
      pxs <= PRW'(in_item.x) * PRW'(cfc_pkg::coef_sp(in_item.sec));
      pyc <= PRW'(in_item.y) * PRW'(cfc_pkg::coef_cp(in_item.sec));
      pz  <= in_item.pz;
      sec <= in_item.sec;
      tag <= in_item.tag;
    end
  end

  // stage 4: rotated coordinates
  always_ff @(posedge clk) begin
    if (load[1]) begin
      out_item.yi  <= pxa + pyb - pz;
      out_item.xi  <= pyc - pxs;
      out_item.sec <= sec;
      out_item.tag <= tag;
    end
  end

endmodule
`default_nettype wire

>>> sv/cfc_strip.sv
`default_nettype none
module cfc_strip #(
  parameter int COORD_FRAC_BITS = cfc_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  cfc_pkg::rot_item_t      in_item,
  input  cfc_pkg::bounds_t        bounds,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output cfc_pkg::res_item_t      out_item
);

  localparam int N   = 7;
  localparam int PRW = cfc_pkg::PRW;
  // operand of the u and t multiplies, wide enough for the scaled offsets
  localparam int AW  = ((26 + COORD_FRAC_BITS) > 32 ? 26 + COORD_FRAC_BITS : 32) + 2;
  localparam int PW  = AW + 18;
  localparam int UW  = PW - 32;
  localparam int TW  = PW - 16;
  localparam int SW  = TW + 1;
  localparam int VW  = SW - 16;
  localparam int PW2 = SW + 18;
  localparam int WW  = PW2 - 32;

  localparam longint SCALE = longint'(1) << COORD_FRAC_BITS;
  localparam logic signed [AW-1:0] LOW_C =
    AW'(longint'(cfc_pkg::Q_YLOW) * SCALE);
  localparam logic signed [AW-1:0] TOP_C =
    AW'((2 * longint'(cfc_pkg::Q_YHIGH) - longint'(cfc_pkg::Q_YLOW)) * SCALE);

  localparam logic [16:0]        CU_SINRHO  = 17'(cfc_pkg::Q_INV_SINRHO);
  localparam logic [16:0]        CU_TGRHO   = 17'(cfc_pkg::Q_INV_TGRHO);
  localparam logic [16:0]        CU_2COSRHO = 17'(cfc_pkg::Q_INV_2COSRHO);
  localparam logic signed [17:0] CS_SINRHO  = $signed({1'b0, CU_SINRHO});
  localparam logic signed [17:0] CS_TGRHO   = $signed({1'b0, CU_TGRHO});
  localparam logic signed [17:0] CS_2COSRHO = $signed({1'b0, CU_2COSRHO});

  localparam logic [PW-1:0]  RND32  = PW'(1) << 31;
  localparam logic [PW-1:0]  RND16  = PW'(1) << 15;
  localparam logic [SW-1:0]  RND16S = SW'(1) << 15;
  localparam logic [PW2-1:0] RND32W = PW2'(1) << 31;

  localparam logic signed [WW-1:0] SAT_MAX = WW'(32767);
  localparam logic signed [WW-1:0] SAT_MIN = WW'(-32768);

  function automatic logic signed [15:0] sat16(input logic signed [WW-1:0] a);
    if (a > SAT_MAX) return 16'sh7fff;
    if (a < SAT_MIN) return 16'sh8000;
    return a[15:0];
  endfunction

  logic [N-1:0] vld;
  logic [N-1:0] load;

  logic [2:0] sec_p [N-1];
  logic [5:0] tag_p [N-1];

  // stage 5
  logic signed [AW-1:0]  s5_au, s5_at;
  logic signed [PRW-1:0] s5_xi;
  // stage 6
  logic [34:0]           s6_pul, s6_ptl;
  logic signed [AW-1:0]  s6_puh, s6_pth;
  logic signed [PRW-1:0] s6_xi;
  // stage 7
  logic signed [UW-1:0]  s7_u;
  logic signed [TW-1:0]  s7_t;
  logic signed [PRW-1:0] s7_xi;
  // stage 8
  logic signed [VW-1:0]  s8_v;
  logic signed [SW-1:0]  s8_sw;
  logic                  s8_u_ok;
  logic signed [15:0]    s8_u_sat;
  // stage 9
  logic [34:0]           s9_pwl;
  logic signed [SW-1:0]  s9_pwh;
  logic                  s9_uv_ok;
  logic signed [15:0]    s9_u_sat, s9_v_sat;
  // stage 10
  logic signed [WW-1:0]  s10_w;
  logic                  s10_uv_ok;
  logic signed [15:0]    s10_u_sat, s10_v_sat;

  logic [PW-1:0]  full_u, full_t;
  logic [SW-1:0]  diff_v;
  logic [PW2-1:0] full_w;

  always_comb begin
    load[N-1] = !vld[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      load[i] = !vld[i] || load[i+1];
    end
  end

  assign in_ready  = load[0];
  assign out_valid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (load[0]) vld[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (load[i]) vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      sec_p[0] <= in_item.sec;
      tag_p[0] <= in_item.tag;
    end
    for (int i = 1; i < N - 1; i++) begin
      if (load[i]) begin
        sec_p[i] <= sec_p[i-1];
        tag_p[i] <= tag_p[i-1];
      end
    end
  end

  // recombine split products and round (ties toward plus infinity)
  always_comb begin
    full_u = (PW'(s6_puh) << 18) + PW'(s6_pul) + RND32;
    full_t = (PW'(s6_pth) << 18) + PW'(s6_ptl) + RND16;
    diff_v = SW'(s7_t) - SW'(s7_xi) + RND16S;
    full_w = (PW2'(s9_pwh) << 18) + PW2'(s9_pwl) + RND32W;
  end

  always_ff @(posedge clk) begin
    // stage 5: offset from the strip origin
    if (load[0]) begin
      s5_au <= AW'(in_item.yi) - LOW_C;
      s5_at <= TOP_C - AW'(in_item.yi);
      s5_xi <= in_item.xi;
    end
    // stage 6: 18-bit low and signed high halves times the reciprocals
    if (load[1]) begin
      s6_pul <= 35'(s5_au[17:0]) * 35'(CU_SINRHO);
      s6_puh <= AW'($signed(s5_au[AW-1:18])) * AW'(CS_SINRHO);
      s6_ptl <= 35'(s5_at[17:0]) * 35'(CU_TGRHO);
      s6_pth <= AW'($signed(s5_at[AW-1:18])) * AW'(CS_TGRHO);
      s6_xi  <= s5_xi;
    end
    if (load[2]) begin
      s7_u  <= $signed(full_u[PW-1:32]);
      s7_t  <= $signed(full_t[PW-1:16]);
      s7_xi <= s6_xi;
    end
    if (load[3]) begin
      s8_v     <= $signed(diff_v[SW-1:16]);
      s8_sw    <= SW'(s7_t) + SW'(s7_xi);
      s8_u_ok  <= (s7_u >= UW'($signed(bounds.u_min))) &&
                  (s7_u <= UW'($signed(bounds.u_max)));
      s8_u_sat <= sat16(WW'(s7_u));
    end
    if (load[4]) begin
      s9_pwl   <= 35'(s8_sw[17:0]) * 35'(CU_2COSRHO);
      s9_pwh   <= SW'($signed(s8_sw[SW-1:18])) * SW'(CS_2COSRHO);
      s9_uv_ok <= s8_u_ok && (s8_v <= VW'($signed(bounds.v_max)));
      s9_u_sat <= s8_u_sat;
      s9_v_sat <= sat16(WW'(s8_v));
    end
    if (load[5]) begin
      s10_w     <= $signed(full_w[PW2-1:32]);
      s10_uv_ok <= s9_uv_ok;
      s10_u_sat <= s9_u_sat;
      s10_v_sat <= s9_v_sat;
    end
    if (load[6]) begin
      out_item.in_cut <= s10_uv_ok && (s10_w <= WW'($signed(bounds.w_max)));
      out_item.sec    <= sec_p[5];
      out_item.u      <= s10_u_sat;
      out_item.v      <= s10_v_sat;
      out_item.w      <= sat16(s10_w);
      out_item.tag    <= tag_p[5];
    end
  end

endmodule
`default_nettype wire

>>> sv/calorimeter_fiducial_cut.sv
`default_nettype none
// Channel   Handshake               Payload
// config    psel/penable/pwrite     paddr[3:2] picks u_minimum, u_maximum, v_maximum,
//           pready (always high)    w_maximum; pwdata[15:0] signed bound, prdata reads back
// hit in    in_valid / in_ready     hit_x, hit_y, hit_z (signed 1/16 cm), track_tag
// cut out   out_valid / out_ready   inside_res, sector, coord_u/v/w, track_tag_out
//
// One item per cycle through 11 register stages while the output does not stall: two
// stages for squares and sector decision, two for the tilted-frame rotation, seven for
// the strip coordinates (u, t and w multiplies are split into an 18-bit low and a
// signed high half each).
// rst is synchronous, clears the stage valid bits and resets the bound registers.
// A stall at the output holds the last stage; bubbles in front still collapse,
// so in_ready stays high while any stage is empty.
module calorimeter_fiducial_cut #(
  parameter int COORD_FRAC_BITS = cfc_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [cfc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [cfc_pkg::PDATA_W-1:0] pwdata,
  output logic      [cfc_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [15:0]          hit_x,
  input  wire logic signed [15:0]          hit_y,
  input  wire logic signed [15:0]          hit_z,
  input  wire logic [5:0]                  track_tag,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             inside_res,
  output logic [2:0]                       sector,
  output logic signed [15:0]               coord_u,
  output logic signed [15:0]               coord_v,
  output logic signed [15:0]               coord_w,
  output logic [5:0]                       track_tag_out
);

  cfc_pkg::bounds_t   bounds;
  cfc_pkg::sec_item_t sec_item;
  cfc_pkg::rot_item_t rot_item;
  cfc_pkg::res_item_t res_item;

  logic sec_valid, sec_ready;
  logic rot_valid, rot_ready;

  // zero-wait APB
  assign pready = 1'b1;

  cfc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .bounds  (bounds)
  );

  // sector from exact half-plane tests
  cfc_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .hit_x     (hit_x),
    .hit_y     (hit_y),
    .hit_z     (hit_z),
    .track_tag (track_tag),
    .out_valid (sec_valid),
    .out_ready (sec_ready),
    .out_item  (sec_item)
  );

  // rotate into the tilted sector frame
  cfc_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sec_valid),
    .in_ready  (sec_ready),
    .in_item   (sec_item),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_item  (rot_item)
  );

  // u/v/w strips, bound checks, saturation; last stage is the output register
  cfc_strip #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_strip (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_item   (rot_item),
    .bounds    (bounds),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (res_item)
  );

  assign inside_res    = res_item.in_cut;
  assign sector        = res_item.sec;
  assign coord_u       = res_item.u;
  assign coord_v       = res_item.v;
  assign coord_w       = res_item.w;
  assign track_tag_out = res_item.tag;

endmodule
`default_nettype wire

>>> bench/cfc_checker.sv
`default_nettype none
module cfc_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic                          pready,
  input  wire logic [cfc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [cfc_pkg::PDATA_W-1:0]   pwdata,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic signed [15:0]            hit_x,
  input  wire logic signed [15:0]            hit_y,
  input  wire logic signed [15:0]            hit_z,
  input  wire logic [5:0]                    track_tag,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic                          inside_res,
  input  wire logic [2:0]                    sector,
  input  wire logic signed [15:0]            coord_u,
  input  wire logic signed [15:0]            coord_v,
  input  wire logic signed [15:0]            coord_w,
  input  wire logic [5:0]                    track_tag_out,
  output int                                 mismatches,
  output int                                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  cfc_pkg::bounds_t   bounds;
  cfc_pkg::res_item_t pending_cuts[$];
  cfc_pkg::res_item_t oldest;

  // sign of sqrt(3)*p - q, exact
  function automatic int sign_root3(input longint p, input longint q);
    longint d;
    if (p >= 0 && q <= 0) return (p == 0 && q == 0) ? 0 : 1;
    if (p <= 0 && q >= 0) return -1;
    d = 3 * p * p - q * q;
    if (p < 0) d = -d;
    return (d > 0) ? 1 : ((d < 0) ? -1 : 0);
  endfunction

  function automatic logic [2:0] sector_of(input longint x, input longint y);
    int lo_side, hi_side;
    bit past_30, left_half, past_330;
    lo_side   = sign_root3(y, x);
    hi_side   = sign_root3(-y, x);
    past_30   = lo_side > 0 || (lo_side == 0 && y > 0);
    left_half = x < 0 || (x == 0 && y > 0);
    past_330  = hi_side > 0 || (hi_side == 0 && y > 0);
    if (past_30) return 3'd1 + 3'(left_half) + 3'(past_330);
    if (past_330) return left_half ? 3'd4 : 3'd5;
    return 3'd0;
  endfunction

  // Q16 rotation terms of sector k: cos25*cos60k, cos25*sin60k, sin60k, cos60k
  function automatic void sector_frame(input logic [2:0] k,
                                       output longint ctc, output longint cts,
                                       output longint sn, output longint cs);
    case (k)
      3'd0:    begin ctc = 59396;  cts = 0;      sn = 0;      cs = 65536;  end
      3'd1:    begin ctc = 29698;  cts = 51438;  sn = 56756;  cs = 32768;  end
      3'd2:    begin ctc = -29698; cts = 51438;  sn = 56756;  cs = -32768; end
      3'd3:    begin ctc = -59396; cts = 0;      sn = 0;      cs = -65536; end
      3'd4:    begin ctc = -29698; cts = -51438; sn = -56756; cs = -32768; end
      default: begin ctc = 29698;  cts = -51438; sn = -56756; cs = 32768;  end
    endcase
  endfunction

  // shift right with rounding, ties toward plus infinity
  function automatic longint round_shift(input longint a, input int s);
    return (a + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [15:0] clamp16(input longint a);
    if (a > 32767) return 16'sh7fff;
    if (a < -32768) return 16'sh8000;
    return 16'(a);
  endfunction

  function automatic cfc_pkg::res_item_t fiducial_result(input logic signed [15:0] hx,
                                                         input logic signed [15:0] hy,
                                                         input logic signed [15:0] hz,
                                                         input logic [5:0] tag,
                                                         input cfc_pkg::bounds_t lim);
    longint x, y, z, ctc, cts, sn, cs, yi, xi, low, high, u, t, v, w;
    logic [2:0] k;
    cfc_pkg::res_item_t r;
    x = hx;
    y = hy;
    z = hz;
    low  = longint'(cfc_pkg::Q_YLOW) * (longint'(1) << cfc_pkg::COORD_FRAC_BITS_DEF);
    high = longint'(cfc_pkg::Q_YHIGH) * (longint'(1) << cfc_pkg::COORD_FRAC_BITS_DEF);
    k = sector_of(x, y);
    sector_frame(k, ctc, cts, sn, cs);
    yi = x * ctc + y * cts - z * cfc_pkg::Q_SIN_TILT;
    xi = -x * sn + y * cs;
    u = round_shift((yi - low) * cfc_pkg::Q_INV_SINRHO, 32);
    t = round_shift(((high - low) + (high - yi)) * cfc_pkg::Q_INV_TGRHO, 16);
    v = round_shift(t - xi, 16);
    w = round_shift((t + xi) * cfc_pkg::Q_INV_2COSRHO, 32);
    // bounds see the unsaturated values
    r.in_cut = (u >= $signed(lim.u_min)) && (u <= $signed(lim.u_max)) &&
               (v <= $signed(lim.v_max)) && (w <= $signed(lim.w_max));
    r.sec = k;
    r.u   = clamp16(u);
    r.v   = clamp16(v);
    r.w   = clamp16(w);
    r.tag = tag;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      bounds = '{u_min: cfc_pkg::U_MIN_RST, u_max: cfc_pkg::U_MAX_RST,
                 v_max: cfc_pkg::V_MAX_RST, w_max: cfc_pkg::W_MAX_RST};
      pending_cuts.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfc_pkg::reg_idx_t'(paddr[3:2]))
          cfc_pkg::REG_U_MIN: bounds.u_min = pwdata[15:0];
          cfc_pkg::REG_U_MAX: bounds.u_max = pwdata[15:0];
          cfc_pkg::REG_V_MAX: bounds.v_max = pwdata[15:0];
          cfc_pkg::REG_W_MAX: bounds.w_max = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_cuts.push_back(fiducial_result(hit_x, hit_y, hit_z, track_tag, bounds));
      if (out_valid && out_ready) begin
        if (pending_cuts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cut: unexpected item tag=%0d u=%0d v=%0d w=%0d",
                     track_tag_out, coord_u, coord_v, coord_w);
        end else begin
          oldest = pending_cuts.pop_front();
          if (oldest.in_cut !== inside_res || oldest.sec !== sector ||
              oldest.u !== coord_u || oldest.v !== coord_v ||
              oldest.w !== coord_w || oldest.tag !== track_tag_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cut: expected in=%0b sec=%0d u=%0d v=%0d w=%0d tag=%0d",
                       oldest.in_cut, oldest.sec, oldest.u, oldest.v, oldest.w,
                       oldest.tag);
              $display("cut:      got in=%0b sec=%0d u=%0d v=%0d w=%0d tag=%0d",
                       inside_res, sector, coord_u, coord_v, coord_w, track_tag_out);
            end
          end
        end
      end
    end
    outstanding = pending_cuts.size();
  end

endmodule
`default_nettype wire

>>> bench/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // accepting edge to the earliest edge at which the item can leave
  localparam int PIPE_LATENCY = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 96;
  localparam real PI_VAL      = 3.14159265358979;

  logic                             clk;
  logic                             rst;
  logic                             psel, penable, pwrite;
  logic [cfc_pkg::PADDR_W-1:0]      paddr;
  logic [cfc_pkg::PDATA_W-1:0]      pwdata;
  logic [cfc_pkg::PDATA_W-1:0]      prdata;
  logic                             pready;
  logic                             in_valid, in_ready;
  logic signed [15:0]               hit_x, hit_y, hit_z;
  logic [5:0]                       track_tag;
  logic                             out_valid, out_ready;
  logic                             inside_res;
  logic [2:0]                       sector;
  logic signed [15:0]               coord_u, coord_v, coord_w;
  logic [5:0]                       track_tag_out;

  int  mismatches;
  int  outstanding;
  int  cycle_count;
  bit  no_idle;        // both sides run flat out while set
  bit  hold_request;   // ask the receiver for one long hold-off

  calorimeter_fiducial_cut dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z), .track_tag(track_tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .sector(sector),
    .coord_u(coord_u), .coord_v(coord_v), .coord_w(coord_w),
    .track_tag_out(track_tag_out)
  );

  cfc_checker check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .hit_x(hit_x), .hit_y(hit_y), .hit_z(hit_z), .track_tag(track_tag),
    .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .sector(sector),
    .coord_u(coord_u), .coord_v(coord_v), .coord_w(coord_w),
    .track_tag_out(track_tag_out),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: end the run if it stalls far beyond any correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Receiver: drop ready about one cycle in five, never while no_idle is set,
  // and hold it low for a long stretch on request so the pipeline fills up
  // and in_ready falls while the sender keeps offering.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 21);
      end
      @(posedge clk);
    end
  end

  // Offer one hit and hold it until the block takes it. Returns at the edge
  // of acceptance without touching in_valid, so the next call can keep it high.
  task automatic send_hit(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z, input logic [5:0] tag);
    while (!no_idle && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    hit_x     <= x;
    hit_y     <= y;
    hit_z     <= z;
    track_tag <= tag;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(4))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'sh0001;
    endcase
  endfunction

  // Mix of hit shapes: near the origin (mostly inside the cut), hugging a
  // sector boundary ray, corner values, and anything the 16 bits allow.
  task automatic pick_hit(output logic signed [15:0] x, output logic signed [15:0] y,
                          output logic signed [15:0] z);
    int  mode, ray;
    real radius, angle;
    mode = $urandom_range(99);
    if (mode < 40) begin
      x = 16'(int'($urandom_range(6000)) - 3000);
      y = 16'(int'($urandom_range(6000)) - 3000);
      z = 16'(int'($urandom_range(6000)) - 3000);
    end else if (mode < 55) begin
      ray    = $urandom_range(5);
      angle  = (30.0 + 60.0 * ray) * PI_VAL / 180.0;
      radius = $urandom_range(32000, 1);
      x = 16'($rtoi(radius * $cos(angle)) + int'($urandom_range(2)) - 1);
      y = 16'($rtoi(radius * $sin(angle)) + int'($urandom_range(2)) - 1);
      z = 16'(int'($urandom_range(4000)) - 2000);
    end else if (mode < 65) begin
      x = corner_value();
      y = corner_value();
      z = corner_value();
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end
  endtask

  task automatic run_hits(input int count);
    logic signed [15:0] x, y, z;
    repeat (count) begin
      pick_hit(x, y, z);
      send_hit(x, y, z, 6'($urandom_range(63)));
    end
    in_valid <= 1'b0;
  endtask

  // Setup then access; leave psel up so a following write can start at once.
  task automatic write_bound(input cfc_pkg::reg_idx_t idx, input logic signed [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_bounds(input logic signed [15:0] u_lo, input logic signed [15:0] u_hi,
                            input logic signed [15:0] v_hi, input logic signed [15:0] w_hi);
    write_bound(cfc_pkg::REG_U_MIN, u_lo);
    write_bound(cfc_pkg::REG_U_MAX, u_hi);
    write_bound(cfc_pkg::REG_V_MAX, v_hi);
    write_bound(cfc_pkg::REG_W_MAX, w_hi);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] near_nominal(input int nominal);
    return 16'(nominal + int'($urandom_range(2048)) - 1024);
  endfunction

  // Wait until every predicted item has come out, then let the pipe settle.
  task automatic wait_drained();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    // every input known from time zero
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    hit_x        = '0;
    hit_y        = '0;
    hit_z        = '0;
    track_tag    = '0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    cycle_count  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed hits under the reset bounds.
    // origin falls in sector 0, z extremes along the axis
    send_hit(16'sd0, 16'sd0, 16'sd0, 6'd0);
    send_hit(16'sd0, 16'sd0, 16'sh7fff, 6'd63);
    send_hit(16'sd0, 16'sd0, 16'sh8000, 6'd1);
    // points right on the 90 and 270 degree rays belong to the sector they open
    send_hit(16'sd0, 16'sd100, 16'sd0, 6'd2);
    send_hit(16'sd0, -16'sd100, 16'sd0, 6'd3);
    send_hit(16'sd0, 16'sh7fff, 16'sd0, 6'd4);
    send_hit(16'sd0, 16'sh8000, 16'sd0, 6'd5);
    send_hit(16'sh7fff, 16'sd0, 16'sd0, 6'd6);
    send_hit(16'sh8000, 16'sd0, 16'sd0, 6'd7);
    // corners: coordinates far out of range, checked before saturation
    send_hit(16'sh7fff, 16'sh7fff, 16'sh7fff, 6'd8);
    send_hit(16'sh8000, 16'sh8000, 16'sh8000, 6'd9);
    send_hit(16'sh7fff, 16'sh8000, 16'sh8000, 6'd10);
    send_hit(16'sh8000, 16'sh7fff, 16'sh7fff, 6'd11);
    // straddle the 30, 150, 210 and 330 degree rays
    send_hit(16'sd56, 16'sd32, 16'sd0, 6'd12);
    send_hit(16'sd56, 16'sd33, 16'sd0, 6'd13);
    send_hit(-16'sd56, 16'sd32, 16'sd0, 6'd14);
    send_hit(-16'sd56, 16'sd33, 16'sd0, 6'd15);
    send_hit(-16'sd56, -16'sd32, 16'sd0, 6'd16);
    send_hit(-16'sd56, -16'sd33, 16'sd0, 6'd17);
    send_hit(16'sd56, -16'sd32, 16'sd0, 6'd18);
    send_hit(16'sd56, -16'sd33, 16'sd0, 6'd19);
    // ordinary hits inside the active area, then the 5555/aaaa pattern
    send_hit(16'sd800, -16'sd300, 16'sd500, 6'd20);
    send_hit(-16'sd1600, 16'sd1200, -16'sd200, 6'd21);
    send_hit(16'sh5555, 16'shaaaa, 16'sh5555, 6'd42);
    in_valid <= 1'b0;

    // Reset bounds, random hits.
    run_hits(260);
    wait_drained();

    // Widest window: only u, v or w past the 16-bit limits can still fail.
    set_bounds(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    no_idle = 1'b1;
    run_hits(260);
    no_idle = 1'b0;
    wait_drained();

    // Empty window, with one long output hold-off to fill the pipe.
    set_bounds(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
    hold_request = 1'b1;
    run_hits(260);
    wait_drained();

    // Bounds scattered around their nominal values.
    set_bounds(near_nominal(1120), near_nominal(6480), near_nominal(5792), near_nominal(6320));
    run_hits(250);
    wait_drained();
    set_bounds(near_nominal(1120), near_nominal(6480), near_nominal(5792), near_nominal(6320));
    hold_request = 1'b1;
    run_hits(250);
    wait_drained();

    repeat (3 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
